// File: src/mvws_pkg.sv
// ----------------------------------------------------------------------------
// mvws_pkg: shared types, constants and step table
// voice and wave sizes, command/status structs and the note phase-step rom
// ----------------------------------------------------------------------------
package mvws_pkg;

	localparam int VOICE_COUNT = 64;
	localparam int WAVE_DEPTH = 2048;
	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int WA = $clog2(WAVE_DEPTH);
	localparam int PROD_W = 23;
	localparam int ACC_W = PROD_W + $clog2(VOICE_COUNT) + 1;

	localparam logic [1:0] OP_MIDI = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_WAVE = 2'd2;

	localparam logic [3:0] MT_NOTE_OFF = 4'h8;
	localparam logic [3:0] MT_NOTE_ON = 4'h9;
	localparam logic [3:0] MT_CTRL = 4'hB;
	localparam logic [3:0] MT_BEND = 4'hE;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_ON,
		EV_OFF,
		EV_OFF_ALL
	} ev_t;

	typedef struct packed {
		logic [6:0] note;
		logic [3:0] chan;
		logic [5:0] vel;
		logic [31:0] phase;
		logic [31:0] step;
	} voice_t;

	typedef struct packed {
		logic load;
		logic parse;
		logic wave_wr;
		logic v_clr;
		logic v_inc;
		logic claim;
		logic release_one;
		logic ph_upd;
		logic quo_ld;
		logic prod_ld;
		logic acc_clr;
		logic acc_add;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		ev_t ev;
		logic act;
		logic last;
		logic match;
	} sts_t;

	// float32 emulation used only to build the step table at elaboration
	typedef struct packed {
		logic [63:0] m;
		logic signed [31:0] e;
	} sf_t;

	typedef struct packed {
		logic [63:0] q;
		logic [63:0] r;
	} div_t;

	localparam int unsigned SEMITONE [12] = '{
		1000000, 1059463, 1122462, 1189207, 1259921, 1334840,
		1414214, 1498307, 1587401, 1681793, 1781797, 1887749
	};

	function automatic sf_t sf_round(logic [63:0] q, int e, logic sticky);
		sf_t r;
		int s;
		logic [63:0] kept;
		logic [63:0] low;
		logic guard;
		logic stk;
		s = 0;
		stk = sticky;
		while ((q >> s) >= 64'd16777216) s++;
		if (s > 0) begin
			kept = q >> s;
			guard = q[s-1];
			low = q & ((64'd1 << (s - 1)) - 64'd1);
			if (low != 64'd0) stk = 1'b1;
			if (guard && (stk || kept[0])) kept = kept + 64'd1;
			if ((kept >> 24) != 64'd0) begin
				kept = kept >> 1;
				s++;
			end
			r.m = kept;
			r.e = 32'(e + s);
		end else begin
			r.m = q;
			r.e = 32'(e);
		end
		return r;
	endfunction

	function automatic div_t udiv(logic [63:0] n, logic [63:0] d);
		div_t res;
		logic [63:0] rem;
		rem = 64'd0;
		res.q = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem = rem - d;
				res.q[i] = 1'b1;
			end
		end
		res.r = rem;
		return res;
	endfunction

	function automatic sf_t sf_mul(sf_t a, sf_t b);
		return sf_round(a.m * b.m, int'(a.e) + int'(b.e), 1'b0);
	endfunction

	function automatic sf_t sf_recip(sf_t d);
		div_t dv;
		dv = udiv(64'd1 << 50, d.m);
		return sf_round(dv.q, -50 - int'(d.e), dv.r != 64'd0);
	endfunction

	function automatic sf_t sf_ratio(int unsigned mil);
		logic [63:0] n;
		n = 64'(mil) << 24;
		return sf_round(n / 64'd1000000, -24, (n % 64'd1000000) != 64'd0);
	endfunction

	function automatic logic [31:0] sf_trunc(sf_t f);
		logic [63:0] t;
		if (f.e >= 0) begin
			if (f.e >= 8) return 32'hFFFF_FFFF;
			t = f.m << f.e;
			return t[31:0];
		end
		if (f.e <= -63) return 32'd0;
		t = f.m >> (-f.e);
		return t[31:0];
	endfunction

	function automatic logic [127:0][31:0] build_step_rom();
		logic [127:0][31:0] rom;
		logic [63:0] n32;
		sf_t scale;
		sf_t a4;
		sf_t mult;
		sf_t d;
		int w;
		n32 = 64'd1 << 56;
		scale = sf_round(n32 / 64'd48000, -24, (n32 % 64'd48000) != 64'd0);
		a4.m = 64'd440;
		a4.e = 32'sd0;
		for (int n = 0; n < 128; n++) begin
			w = n - 69;
			if (w >= 0) begin
				mult = sf_ratio(SEMITONE[w % 12]);
				mult.e = mult.e + 32'(w / 12);
			end else begin
				w = -w;
				d = sf_ratio(SEMITONE[w % 12]);
				d.e = d.e + 32'(w / 12);
				mult = sf_recip(d);
			end
			rom[n] = sf_trunc(sf_mul(sf_mul(a4, mult), scale));
		end
		return rom;
	endfunction

	localparam logic [127:0][31:0] STEP_ROM = build_step_rom();

endpackage

// File: src/mvws_ctrl.sv
// ----------------------------------------------------------------------------
// mvws_ctrl: sequencer
// walks the voices for note-on, note-off and sample ticks
// ----------------------------------------------------------------------------
module mvws_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mvws_pkg::sts_t  sts,
	output mvws_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            result_valid
);
	import mvws_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MIDI_EV,
		S_ON_CHK,
		S_OFF_RD,
		S_OFF_CMP,
		S_T_RD,
		S_T_PH,
		S_T_MOD1,
		S_T_MOD2,
		S_T_MUL,
		S_T_ACC,
		S_T_OUT
	} state_t;

	state_t state_q;
	logic valid_q;

	assign busy = (state_q != S_IDLE);
	assign result_valid = valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_DECODE: begin
				cmd.parse = (sts.op == OP_MIDI);
				cmd.wave_wr = (sts.op == OP_WAVE);
				cmd.v_clr = 1'b1;
				cmd.acc_clr = (sts.op == OP_TICK);
			end
			S_ON_CHK: begin
				cmd.claim = !sts.act;
				cmd.v_inc = sts.act && !sts.last;
			end
			S_OFF_RD: cmd.v_inc = !sts.act && !sts.last;
			S_OFF_CMP: begin
				cmd.release_one = sts.match;
				cmd.v_inc = !sts.last && !(sts.match && sts.ev == EV_OFF);
			end
			S_T_RD: cmd.v_inc = !sts.act && !sts.last;
			S_T_PH: cmd.ph_upd = 1'b1;
			S_T_MOD1: cmd.quo_ld = 1'b1;
			S_T_MUL: cmd.prod_ld = 1'b1;
			S_T_ACC: begin
				cmd.acc_add = 1'b1;
				cmd.v_inc = !sts.last;
			end
			S_T_OUT: cmd.out_ld = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_DECODE;
				S_DECODE: begin
					case (sts.op)
						OP_MIDI: state_q <= S_MIDI_EV;
						OP_TICK: state_q <= S_T_RD;
						default: state_q <= S_IDLE;
					endcase
				end
				S_MIDI_EV: begin
					case (sts.ev)
						EV_ON: state_q <= S_ON_CHK;
						EV_OFF, EV_OFF_ALL: state_q <= S_OFF_RD;
						default: state_q <= S_IDLE;
					endcase
				end
				S_ON_CHK: if (!sts.act || sts.last) state_q <= S_IDLE;
				S_OFF_RD: begin
					if (sts.act) state_q <= S_OFF_CMP;
					else if (sts.last) state_q <= S_IDLE;
				end
				S_OFF_CMP: begin
					if (sts.last || (sts.match && sts.ev == EV_OFF)) state_q <= S_IDLE;
					else state_q <= S_OFF_RD;
				end
				S_T_RD: begin
					if (sts.act) state_q <= S_T_PH;
					else if (sts.last) state_q <= S_T_OUT;
				end
				S_T_PH: state_q <= S_T_MOD1;
				S_T_MOD1: state_q <= S_T_MOD2;
				S_T_MOD2: state_q <= S_T_MUL;
				S_T_MUL: state_q <= S_T_ACC;
				S_T_ACC: state_q <= sts.last ? S_T_OUT : S_T_RD;
				S_T_OUT: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/mvws_dp.sv
// ----------------------------------------------------------------------------
// mvws_dp: datapath
// midi parser, voice store, wave memory, multiplier and mix accumulator
// ----------------------------------------------------------------------------
module mvws_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mvws_pkg::cmd_t      cmd,
	output mvws_pkg::sts_t      sts,
	input  logic [1:0]          op,
	input  logic [7:0]          midi_data,
	input  logic [10:0]         wave_addr,
	input  logic signed [15:0]  wave_value,
	output logic signed [31:0]  left_sample,
	output logic signed [31:0]  right_sample
);
	import mvws_pkg::*;

	localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(WAVE_DEPTH) - 64'd1)
		/ 64'(WAVE_DEPTH));
	localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(24'sh7FFFFF);
	localparam logic signed [ACC_W-1:0] MIX_MIN = ACC_W'(-25'sh800000);

	// latched item
	logic [1:0] op_q;
	logic [7:0] byte_q;
	logic [10:0] waddr_q;
	logic signed [15:0] wval_q;

	// parser
	logic [7:0] rs_q;
	logic [6:0] first_q;
	logic dc_q;
	ev_t ev_q;

	// voices
	logic [VOICE_COUNT-1:0] active_q;
	voice_t voice_mem [VOICE_COUNT];
	voice_t rd_q;
	voice_t wr_rec;
	logic wr_en;
	logic [VW-1:0] v_q;

	// wave path
	logic signed [15:0] wave_mem [WAVE_DEPTH];
	logic signed [15:0] wdata_q;
	logic [15:0] idx_q;
	logic [15:0] quo_q;
	logic [48:0] quo_full;
	logic [31:0] rem_full;
	logic [31:0] new_phase;
	logic [16:0] waddr_ext;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [23:0] mix24;
	logic [31:0] out_q;

	assign sts.op = op_q;
	assign sts.ev = ev_q;
	assign sts.act = active_q[v_q];
	assign sts.last = (v_q == VW'(VOICE_COUNT - 1));
	assign sts.match = (rd_q.note == first_q) && (rd_q.chan == rs_q[3:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			byte_q <= midi_data;
			waddr_q <= wave_addr;
			wval_q <= wave_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= 8'd0;
			first_q <= 7'd0;
			dc_q <= 1'b0;
			ev_q <= EV_NONE;
		end else if (cmd.parse) begin
			ev_q <= EV_NONE;
			if (byte_q[7]) begin
				rs_q <= byte_q;
				dc_q <= 1'b0;
			end else if (rs_q[7:4] == MT_NOTE_OFF || rs_q[7:4] == MT_NOTE_ON
					|| rs_q[7:4] == MT_CTRL || rs_q[7:4] == MT_BEND) begin
				if (!dc_q) begin
					first_q <= byte_q[6:0];
					dc_q <= 1'b1;
				end else begin
					dc_q <= 1'b0;
					if (rs_q[7:4] == MT_NOTE_OFF) ev_q <= EV_OFF;
					else if (rs_q[7:4] == MT_NOTE_ON)
						ev_q <= (byte_q == 8'd0) ? EV_OFF_ALL : EV_ON;
				end
			end else begin
				dc_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			active_q <= '0;
		end else begin
			if (cmd.v_clr) v_q <= '0;
			else if (cmd.v_inc) v_q <= v_q + VW'(1);
			if (cmd.claim) active_q[v_q] <= 1'b1;
			else if (cmd.release_one) active_q[v_q] <= 1'b0;
		end
	end

	// voice store: one write, one registered read at the walk index
	assign new_phase = rd_q.phase + rd_q.step;
	assign wr_en = cmd.claim || cmd.ph_upd;

	always_comb begin
		wr_rec = rd_q;
		wr_rec.phase = new_phase;
		if (cmd.claim) begin
			wr_rec.note = first_q;
			wr_rec.chan = rs_q[3:0];
			wr_rec.vel = byte_q[6:1];
			wr_rec.phase = 32'd0;
			wr_rec.step = STEP_ROM[first_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) voice_mem[v_q] <= wr_rec;
		rd_q <= voice_mem[v_q];
	end

	// wave index modulo depth: reciprocal multiply, then back-multiply
	assign quo_full = 49'(idx_q) * 49'(RECIP);
	assign rem_full = 32'(idx_q) - 32'(quo_q) * 32'(WAVE_DEPTH);
	assign waddr_ext = 17'(waddr_q);

	always_ff @(posedge clk) begin
		if (cmd.ph_upd) idx_q <= new_phase[31:16];
		if (cmd.quo_ld) quo_q <= quo_full[47:32];
		if (cmd.wave_wr && (waddr_ext < 17'(WAVE_DEPTH)))
			wave_mem[waddr_ext[WA-1:0]] <= wval_q;
		wdata_q <= wave_mem[rem_full[WA-1:0]];
		if (cmd.prod_ld) prod_q <= PROD_W'(wdata_q) * PROD_W'($signed({1'b0, rd_q.vel}));
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= acc_q + ACC_W'(prod_q);
		if (cmd.out_ld) out_q <= {mix24, 8'd0};
	end

	always_comb begin
		if (acc_q > MIX_MAX) mix24 = 24'h7FFFFF;
		else if (acc_q < MIX_MIN) mix24 = 24'h800000;
		else mix24 = acc_q[23:0];
	end

	assign left_sample = out_q;
	assign right_sample = out_q;

endmodule

// File: src/midi_voice_wavetable_synth.sv
// ----------------------------------------------------------------------------
// midi_voice_wavetable_synth: polyphonic wavetable synth with midi voices
// midi running-status parser, lowest-free voice allocation, per-tick mix
// ----------------------------------------------------------------------------
//
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+------------------
// item in   | op, midi_data, wave_addr, wave_value         | start && !busy
// result    | left_sample, right_sample                    | result_valid
//
// a midi byte passes the decode and event states, a wave write or an unused op
// only the decode state; a completed note-on then walks voices one per cycle until
// a free one is found or the last voice is reached; note-off reads each voice and
// compares each active one against the note and channel.
// a sample tick reads each voice and, for an active one, steps the phase, reduces
// the wave index, multiplies and accumulates (one shared velocity multiplier and
// one wave memory port), then loads the output; the result strobes in the same cycle
// that busy falls. reset clears parser, voice active bits and sequencer; wave memory is
// undefined until written. results show for one cycle and cannot stall.
//
module midi_voice_wavetable_synth (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          op,
	input  logic [7:0]          midi_data,
	input  logic [10:0]         wave_addr,
	input  logic signed [15:0]  wave_value,
	output logic                result_valid,
	output logic signed [31:0]  left_sample,
	output logic signed [31:0]  right_sample
);
	import mvws_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: issues commands per beat and per voice step
	mvws_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// datapath: parser, voice store, wave memory, mix
	mvws_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.midi_data    (midi_data),
		.wave_addr    (wave_addr),
		.wave_value   (wave_value),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

	// an accepted beat always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start work");

	// results strobe for a single cycle
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// both channels equal and left-aligned
	a_out_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (left_sample == right_sample) && (left_sample[7:0] == 8'd0))
		else $error("malformed result");

endmodule

// File: tb/sv/tb_midi_voice_wavetable_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_voice_wavetable_synth: self-checking bench for the wavetable synth
// drives directed and random midi traffic, ticks and wave writes with random
// gaps; wave entries are written before the first tick that reads them and a
// local voice model predicts every mix
// ----------------------------------------------------------------------------
module tb_midi_voice_wavetable_synth;
	import mvws_pkg::*;

	localparam int NVOICE = 64;
	localparam int NWAVE = 2048;
	localparam int QUIET_LIMIT = 4000;	// cycles with no beat on either side
	localparam int DRAIN_CYCLES = 600;	// longer than a full 64-voice tick

	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON = 8'h90;
	localparam logic [7:0] ST_CTRL = 8'hB0;
	localparam logic [7:0] ST_PROG = 8'hC0;
	localparam logic [7:0] ST_BEND = 8'hE0;
	localparam logic [7:0] ST_CLOCK = 8'hF8;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] midi_data;
		logic [10:0] wave_addr;
		logic signed [15:0] wave_value;
	} beat_t;

	// float32 value as mantissa and binary exponent
	typedef struct {
		longint unsigned m;
		int e;
	} fp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_MIDI;
	logic [7:0] midi_data = 8'd0;
	logic [10:0] wave_addr = 11'd0;
	logic signed [15:0] wave_value = 16'sd0;
	logic result_valid;
	logic signed [31:0] left_sample;
	logic signed [31:0] right_sample;

	midi_voice_wavetable_synth dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .midi_data(midi_data), .wave_addr(wave_addr),
		.wave_value(wave_value), .result_valid(result_valid),
		.left_sample(left_sample), .right_sample(right_sample)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	beat_t pending_beats[$];
	logic signed [31:0] expected_mix[$];
	int err_count = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	bit no_idle_run = 1'b0;

	// model state
	bit m_active[NVOICE];
	logic [7:0] m_note[NVOICE];
	logic [5:0] m_vel[NVOICE];
	logic [3:0] m_chan[NVOICE];
	logic [31:0] m_phase[NVOICE];
	logic [31:0] m_step[NVOICE];
	logic signed [15:0] m_wave[NWAVE];
	bit m_written[NWAVE];
	logic [7:0] m_status;
	logic [6:0] m_first;
	logic [1:0] m_count;
	logic [31:0] pitch_step[128];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// ---------------- phase step table, float32 arithmetic emulated ----------------

	// round q * 2^e (plus a fraction when sticky) to a 24-bit mantissa, nearest-even
	function automatic fp_t fp_norm(longint unsigned q, int e, bit sticky);
		fp_t r;
		int s;
		longint unsigned kept;
		s = 0;
		while ((q >> s) >= 64'd16777216) s++;
		r.m = q;
		r.e = e;
		if (s > 0) begin
			kept = q >> s;
			if ((q & ((64'd1 << (s - 1)) - 64'd1)) != 0) sticky = 1'b1;
			if (((q >> (s - 1)) & 64'd1) && (sticky || kept[0])) kept++;
			if ((kept >> 24) != 0) begin
				kept = kept >> 1;
				s++;
			end
			r.m = kept;
			r.e = e + s;
		end
		return r;
	endfunction

	function automatic fp_t fp_mul(fp_t a, fp_t b);
		return fp_norm(a.m * b.m, a.e + b.e, 1'b0);
	endfunction

	function automatic fp_t semitone(int k, int octave);
		int unsigned mil[12] = '{1000000, 1059463, 1122462, 1189207, 1259921, 1334840,
			1414214, 1498307, 1587401, 1681793, 1781797, 1887749};
		longint unsigned n;
		fp_t r;
		n = longint'(mil[k]) << 24;
		r = fp_norm(n / 1000000, -24, (n % 1000000) != 0);
		r.e += octave;
		return r;
	endfunction

	function automatic logic [31:0] to_word(fp_t f);
		longint unsigned t;
		if (f.e >= 8) return 32'hFFFF_FFFF;
		if (f.e >= 0) begin
			t = f.m << f.e;
			return t[31:0];
		end
		if (f.e <= -63) return 32'd0;
		t = f.m >> (-f.e);
		return t[31:0];
	endfunction

	task automatic build_pitch_steps();
		fp_t scale, a4, mult, d;
		longint unsigned n32;
		int w;
		n32 = 64'd1 << 56;
		scale = fp_norm(n32 / 48000, -24, (n32 % 48000) != 0);
		a4.m = 440;
		a4.e = 0;
		for (int n = 0; n < 128; n++) begin
			w = n - 69;
			if (w >= 0) mult = semitone(w % 12, w / 12);
			else begin
				d = semitone((-w) % 12, (-w) / 12);
				mult = fp_norm((64'd1 << 50) / d.m, -50 - d.e, ((64'd1 << 50) % d.m) != 0);
			end
			pitch_step[n] = to_word(fp_mul(fp_mul(a4, mult), scale));
		end
	endtask

	// ---------------- voice model ----------------

	task automatic free_voices(input logic [6:0] note, input logic [3:0] chan, input bit all);
		for (int v = 0; v < NVOICE; v++) begin
			if (m_active[v] && m_note[v] == {1'b0, note} && m_chan[v] == chan) begin
				m_active[v] = 1'b0;
				if (!all) begin
					m_vel[v] = 6'd0;
					return;
				end
			end
		end
	endtask

	task automatic parse_midi(input logic [7:0] b);
		logic [3:0] kind;
		if (b[7]) begin
			m_status = b;
			m_count = 2'd0;
			return;
		end
		kind = m_status[7:4];
		if (kind == MT_NOTE_OFF || kind == MT_NOTE_ON || kind == MT_CTRL || kind == MT_BEND) begin
			if (m_count == 2'd0) begin
				m_first = b[6:0];
				m_count = 2'd1;
				return;
			end
			m_count = 2'd0;
			if (kind == MT_NOTE_OFF) free_voices(m_first, m_status[3:0], 1'b0);
			else if (kind == MT_NOTE_ON) begin
				if (b == 8'd0) free_voices(m_first, m_status[3:0], 1'b1);
				else begin
					// lowest free voice takes the note, if any is free
					for (int v = 0; v < NVOICE; v++) begin
						if (!m_active[v]) begin
							m_active[v] = 1'b1;
							m_note[v] = {1'b0, m_first};
							m_vel[v] = b[6:1];
							m_chan[v] = m_status[3:0];
							m_phase[v] = 32'd0;
							m_step[v] = pitch_step[m_first];
							break;
						end
					end
				end
			end
		end else m_count = 2'd0;
	endtask

	// apply one beat in queue order; a tick queues the mix it must produce
	task automatic apply_beat(input beat_t b);
		longint mix;
		logic [31:0] word;
		case (b.op)
			OP_MIDI: parse_midi(b.midi_data);
			OP_WAVE: begin
				m_wave[b.wave_addr] = b.wave_value;
				m_written[b.wave_addr] = 1'b1;
			end
			OP_TICK: begin
				mix = 0;
				for (int v = 0; v < NVOICE; v++) begin
					if (m_active[v]) begin
						m_phase[v] = m_phase[v] + m_step[v];
						mix += longint'(m_wave[m_phase[v][26:16]]) * longint'(m_vel[v]);
					end
				end
				if (mix > 64'sh7FFFFF) mix = 64'sh7FFFFF;
				if (mix < -64'sh800000) mix = -64'sh800000;
				word = {mix[23:0], 8'd0};
				expected_mix.push_back(word);
			end
			default: ;
		endcase
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic add_beat(input logic [1:0] o, input logic [7:0] mb,
		input logic [10:0] wa, input logic [15:0] wv);
		beat_t b;
		beat_t w;
		logic [31:0] ph;
		b.op = o;
		b.midi_data = mb;
		b.wave_addr = wa;
		b.wave_value = wv;
		// write any wave entry this tick would read before it is written
		if (o == OP_TICK) begin
			for (int v = 0; v < NVOICE; v++) begin
				ph = m_phase[v] + m_step[v];
				if (m_active[v] && !m_written[ph[26:16]]) begin
					w.op = OP_WAVE;
					w.midi_data = 8'($urandom);
					w.wave_addr = ph[26:16];
					w.wave_value = 16'($urandom);
					apply_beat(w);
					pending_beats.push_back(w);
				end
			end
		end
		apply_beat(b);
		pending_beats.push_back(b);
	endtask

	task automatic add_msg(input logic [7:0] st, input int nbytes, input logic [7:0] d1,
		input logic [7:0] d2);
		// status of zero means lean on running status
		if (st != 8'd0) add_beat(OP_MIDI, st, 11'($urandom), 16'($urandom));
		if (nbytes > 0) add_beat(OP_MIDI, d1, 11'($urandom), 16'($urandom));
		if (nbytes > 1) add_beat(OP_MIDI, d2, 11'($urandom), 16'($urandom));
	endtask

	function automatic logic [6:0] pick_note();
		if ($urandom_range(0, 1)) return 7'(60 + $urandom_range(0, 3));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic logic [3:0] pick_chan();
		if ($urandom_range(0, 3) != 0) return 4'($urandom_range(0, 1));
		return 4'($urandom_range(0, 15));
	endfunction

	// ---------------- driver ----------------

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				void'(pending_beats.pop_front());
				if ($urandom_range(0, 39) == 0) no_idle_run = !no_idle_run;
				gap_left = no_idle_run ? 0 : $urandom_range(0, 14);
			end
			if (start && busy) begin
				// hold the current beat
			end else if (gap_left == 0 && pending_beats.size() > 0) begin
				start <= 1'b1;
				op <= pending_beats[0].op;
				midi_data <= pending_beats[0].midi_data;
				wave_addr <= pending_beats[0].wave_addr;
				wave_value <= pending_beats[0].wave_value;
			end else begin
				start <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
	end

	// ---------------- monitor and watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				if (expected_mix.size() == 0) begin
					report("unexpected result", left_sample, 32'd0);
				end else begin
					if (left_sample !== expected_mix[0]) report("left", left_sample, expected_mix[0]);
					if (right_sample !== expected_mix[0]) report("right", right_sample, expected_mix[0]);
					void'(expected_mix.pop_front());
				end
			end
			if (result_valid || (start && !busy)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		int sel;
		for (int v = 0; v < NVOICE; v++) begin
			m_active[v] = 1'b0;
			m_note[v] = 8'hFF;
			m_vel[v] = 6'd0;
			m_chan[v] = 4'd0;
			m_phase[v] = 32'd0;
			m_step[v] = 32'd0;
		end
		for (int a = 0; a < NWAVE; a++) m_written[a] = 1'b0;
		m_status = 8'd0;
		m_first = 7'd0;
		m_count = 2'd0;
		build_pitch_steps();

		// edge values of the wave sample
		add_beat(OP_WAVE, 8'd0, 11'd0, 16'h7FFF);
		add_beat(OP_WAVE, 8'd0, 11'd2047, 16'h8000);

		// directed: extreme notes and velocities, running status, most message kinds
		add_beat(OP_TICK, 8'd0, 11'd0, 16'd0);	// no voice active
		add_msg(ST_NOTE_ON, 2, 8'd0, 8'd127);
		add_msg(8'd0, 2, 8'd127, 8'd1);		// running status
		add_msg(ST_NOTE_ON | 8'h0F, 2, 8'd69, 8'd64);
		add_beat(OP_TICK, 8'd0, 11'd0, 16'd0);
		add_msg(ST_NOTE_OFF, 1, 8'd0, 8'd0);
		add_beat(OP_MIDI, ST_CLOCK, 11'd0, 16'd0);	// real-time byte mid message
		add_msg(8'd0, 1, 8'd0, 8'd0);		// status now unknown kind
		add_msg(ST_NOTE_OFF, 2, 8'd0, 8'd0);	// note-off frees one voice
		add_msg(ST_CTRL, 2, 8'd7, 8'd100);
		add_msg(ST_PROG, 1, 8'd5, 8'd0);
		add_msg(ST_BEND, 2, 8'd0, 8'd64);
		add_msg(ST_NOTE_ON | 8'h0F, 2, 8'd69, 8'd0);	// velocity zero frees all matching voices
		add_beat(OP_NONE, 8'hFF, 11'h7FF, 16'hFFFF);
		add_beat(OP_TICK, 8'd0, 11'd0, 16'd0);

		// random: mostly well-formed messages, some noise
		for (int i = 0; i < 450; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35)
				add_msg($urandom_range(0, 2) ? (ST_NOTE_ON | {4'h0, pick_chan()}) : 8'd0, 2,
					{1'b0, pick_note()}, 8'($urandom_range(1, 127)));
			else if (sel < 47)
				add_msg(ST_NOTE_OFF | {4'h0, pick_chan()}, 2, {1'b0, pick_note()},
					8'($urandom_range(0, 127)));
			else if (sel < 52)
				add_msg(ST_NOTE_ON | {4'h0, pick_chan()}, 2, {1'b0, pick_note()}, 8'd0);
			else if (sel < 77)
				add_beat(OP_TICK, 8'($urandom), 11'($urandom), 16'($urandom));
			else if (sel < 83)
				add_beat(OP_WAVE, 8'($urandom), 11'($urandom), 16'($urandom));
			else if (sel < 93)
				add_beat(OP_MIDI, 8'($urandom), 11'($urandom), 16'($urandom));
			else if (sel < 97)
				add_msg(8'($urandom_range(8'hA0, 8'hFF)), int'($urandom_range(0, 2)),
					8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
			else
				add_beat(OP_NONE, 8'($urandom), 11'($urandom), 16'($urandom));
		end
		add_beat(OP_TICK, 8'd0, 11'd0, 16'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() > 0 || start) @(posedge clk);
		while (expected_mix.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_mix.size() > 0) report("missing result", 32'd0, 32'd0);

		if (err_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
src/mvws_pkg.sv
src/mvws_ctrl.sv
src/mvws_dp.sv
src/midi_voice_wavetable_synth.sv
tb/sv/tb_midi_voice_wavetable_synth.sv
